// ===== hdl/sdtg_pkg.sv =====
// Shared types and constants for the speed-driven trigger and gain ramp unit.
// Used by every module under hdl; no dependencies.
package sdtg_pkg;

    localparam int SPEED_W    = 16;
    localparam int ELAPSED_W  = 21;
    localparam int RATE_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int WELD_W     = 17;
    localparam int COEFF_W    = 17;
    localparam int RAMP_W     = 24;
    localparam int FRAC_W     = 24;
    localparam int TRIG_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared divider: sized for dividend elapsed << 16 and divisor ramp_time; the rate pass uses it too
    localparam int DIV_N_W   = ELAPSED_W + 16;
    localparam int DIV_D_W   = RAMP_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // shared signed multiplier
    localparam int MUL_A_W = COEFF_W + 1;
    localparam int MUL_B_W = ELAPSED_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = ELAPSED_W'(1048576);
    localparam logic [WELD_W-1:0]    ONE_Q16     = WELD_W'(65536);
    localparam logic [SPEED_W-1:0]   DEFAULT_CAP = SPEED_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_LOW     = 3'd0,
        REG_RATE_HIGH    = 3'd1,
        REG_SPEED_CAP    = 3'd2,
        REG_IDLE_GAIN    = 3'd3,
        REG_ACTIVE_GAIN  = 3'd4,
        REG_ACTIVE_SPEED = 3'd5,
        REG_SMOOTH_COEFF = 3'd6,
        REG_RAMP_TIME    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_low;
        logic [RATE_W-1:0]  rate_high;
        logic [SPEED_W-1:0] speed_cap;
        logic [GAIN_W-1:0]  idle_gain;
        logic [GAIN_W-1:0]  active_gain;
        logic [SPEED_W-1:0] active_speed;
        logic [COEFF_W-1:0] smooth_coeff;
        logic [RAMP_W-1:0]  ramp_time;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_RATE,
        ST_PHASE,
        ST_HISS,
        ST_WDIV_GO,
        ST_WDIV_WAIT,
        ST_WELD,
        ST_DONE
    } seq_state_t;

endpackage

// ===== hdl/sdtg_cfg.sv =====
// Configuration register file for the trigger and gain ramp unit.
// Depends on sdtg_pkg for the register index codes and the cfg_t bundle.
module sdtg_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sdtg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdtg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sdtg_pkg::cfg_t                   cfg
);
    import sdtg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_low     <= '0;
            cfg_reg.rate_high    <= '0;
            cfg_reg.speed_cap    <= DEFAULT_CAP;
            cfg_reg.idle_gain    <= '0;
            cfg_reg.active_gain  <= '0;
            cfg_reg.active_speed <= '0;
            cfg_reg.smooth_coeff <= ONE_Q16;
            cfg_reg.ramp_time    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_RATE_LOW:     cfg_reg.rate_low     <= cfg_data[RATE_W-1:0];
                REG_RATE_HIGH:    cfg_reg.rate_high    <= cfg_data[RATE_W-1:0];
                REG_SPEED_CAP:    cfg_reg.speed_cap    <= cfg_data[SPEED_W-1:0];
                REG_IDLE_GAIN:    cfg_reg.idle_gain    <= cfg_data[GAIN_W-1:0];
                REG_ACTIVE_GAIN:  cfg_reg.active_gain  <= cfg_data[GAIN_W-1:0];
                REG_ACTIVE_SPEED: cfg_reg.active_speed <= cfg_data[SPEED_W-1:0];
                REG_SMOOTH_COEFF: cfg_reg.smooth_coeff <= cfg_data[COEFF_W-1:0];
                REG_RAMP_TIME:    cfg_reg.ramp_time    <= cfg_data[RAMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/sdtg_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on sdtg_pkg for operand widths.
module sdtg_mul (
    input  logic                             aclk,
    input  logic [sdtg_pkg::MUL_A_W-1:0]     mul_a,
    input  logic [sdtg_pkg::MUL_B_W-1:0]     mul_b,
    output logic [sdtg_pkg::MUL_P_W-1:0]     mul_p
);
    import sdtg_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(mul_a) * $signed(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

// ===== hdl/sdtg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on sdtg_pkg for dividend, divisor and counter widths.
module sdtg_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [sdtg_pkg::DIV_N_W-1:0]     dividend,
    input  logic [sdtg_pkg::DIV_D_W-1:0]     divisor,
    output logic                             done,
    output logic [sdtg_pkg::DIV_N_W-1:0]     quotient,
    output logic [sdtg_pkg::DIV_D_W-1:0]     remainder
);
    import sdtg_pkg::*;

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W+1:0]   trial;
    logic                 neg;

    // partial remainder stays below the divisor, so the shifted value fits
    assign trial = {1'b0, rem_reg, quo_reg[DIV_N_W-1]} - {2'b00, den_reg};
    assign neg   = trial[DIV_D_W+1];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            done_next = 1'b0;
        end else if (cnt_reg != '0) begin
            rem_next  = neg ? {rem_reg[DIV_D_W-2:0], quo_reg[DIV_N_W-1]}
                            : trial[DIV_D_W-1:0];
            quo_next  = {quo_reg[DIV_N_W-2:0], ~neg};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/speed_driven_trigger_and_gain_ramps_unit.sv =====
// Speed-driven crackle trigger generator with hiss and weld gain envelopes.
// Takes one frame word on s_* (speed, elapsed, armed) and returns one result word on m_*
// (trigger_count, rate_now, hiss_level, weld_level). Valid/ready on both sides.
// Registers are written through cfg_wr_en / cfg_index / cfg_data with no wait state;
// write them only while no frame is in flight.
// A sequencer drives one shared multiplier and one shared bit-serial divider:
// a division for the rate interpolation, three multiplies, and a second
// division for the weld slew step (skipped when ramp_time is 0).
// s_ready is high only in the idle state, so one frame is worked on at a time
// and a new frame is taken the cycle after the previous result is loaded into
// the output register.
// If the receiver stalls, the finished result waits in the sequencer's last state
// until the output register frees up; the held word on m_* does not change.
// aresetn (synchronous, active low) restores register defaults, clears the phase
// fraction, both gains and the first-frame flag, and drops m_valid.
module speed_driven_trigger_and_gain_ramps_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sdtg_pkg::SPEED_W-1:0]      s_speed,
    input  logic [sdtg_pkg::ELAPSED_W-1:0]    s_elapsed,
    input  logic                              s_armed,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sdtg_pkg::TRIG_W-1:0]       m_trigger_count,
    output logic [sdtg_pkg::RATE_W-1:0]       m_rate_now,
    output logic [sdtg_pkg::GAIN_W-1:0]       m_hiss_level,
    output logic [sdtg_pkg::WELD_W-1:0]       m_weld_level,
    input  logic                              cfg_wr_en,
    input  logic [sdtg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdtg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sdtg_pkg::*;

    cfg_t cfg;

    seq_state_t state_reg, state_next;

    logic [SPEED_W-1:0]   speed_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 armed_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [TRIG_W-1:0]    trig_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [GAIN_W-1:0]    hiss_reg;
    logic [WELD_W-1:0]    weld_reg;
    logic                 primed_reg;
    logic                 m_valid_reg;
    logic [TRIG_W-1:0]    m_trig_reg;
    logic [RATE_W-1:0]    m_rate_reg;
    logic [GAIN_W-1:0]    m_hiss_reg;
    logic [WELD_W-1:0]    m_weld_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic                 div_go;
    logic [DIV_N_W-1:0]   div_dividend;
    logic [DIV_D_W-1:0]   div_divisor;
    logic                 div_done;
    logic [DIV_N_W-1:0]   div_q;
    logic [DIV_D_W-1:0]   div_r;

    logic [ELAPSED_W-1:0] el_clamp;
    logic [SPEED_W-1:0]   cap;
    logic                 rate_up;
    logic [RATE_W-1:0]    rate_span;
    logic                 at_cap;
    logic [RATE_W-1:0]    rate_ceil;
    logic [RATE_W-1:0]    rate_calc;
    logic [COEFF_W-1:0]   coeff;
    logic [GAIN_W-1:0]    hiss_target;
    logic [GAIN_W:0]      hiss_diff;
    logic [GAIN_W+2:0]    hiss_sum;
    logic [FRAC_W+TRIG_W-1:0] phase_acc;
    logic [WELD_W-1:0]    weld_goal;
    logic [WELD_W-1:0]    weld_gap;
    logic [WELD_W-1:0]    weld_calc;
    logic                 out_free;

    sdtg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdtg_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    sdtg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // ---------------- datapath helpers ----------------
    assign el_clamp  = (s_elapsed > ELAPSED_MAX) ? ELAPSED_MAX : s_elapsed;
    assign cap       = (cfg.speed_cap == '0) ? DEFAULT_CAP : cfg.speed_cap;
    assign rate_up   = (cfg.rate_high >= cfg.rate_low);
    assign rate_span = rate_up ? (cfg.rate_high - cfg.rate_low)
                               : (cfg.rate_low - cfg.rate_high);
    assign at_cap    = (speed_reg >= cap);

    // falling ramp rounds the interpolation term up so the rate floors overall
    assign rate_ceil = div_q[RATE_W-1:0] + RATE_W'(div_r != '0);
    assign rate_calc = at_cap  ? cfg.rate_high :
                       rate_up ? (cfg.rate_low + div_q[RATE_W-1:0])
                               : (cfg.rate_low - rate_ceil);

    assign coeff       = (cfg.smooth_coeff > ONE_Q16) ? ONE_Q16 : cfg.smooth_coeff;
    assign hiss_target = (speed_reg >= cfg.active_speed) ? cfg.active_gain : cfg.idle_gain;
    assign hiss_diff   = {1'b0, hiss_target} - {1'b0, hiss_reg};
    // arithmetic shift of the signed product by 16 gives the floor
    assign hiss_sum    = {3'b000, hiss_reg} + mul_p[GAIN_W+18:16];

    assign phase_acc = mul_p[FRAC_W+TRIG_W-1:0] + {{TRIG_W{1'b0}}, frac_reg};

    assign weld_goal = armed_reg ? ONE_Q16 : '0;
    assign weld_gap  = (weld_reg >= weld_goal) ? (weld_reg - weld_goal)
                                               : (weld_goal - weld_reg);
    always_comb begin
        if (cfg.ramp_time == '0) begin
            weld_calc = weld_goal;
        end else if (div_q >= {{(DIV_N_W-WELD_W){1'b0}}, weld_gap}) begin
            weld_calc = weld_goal;
        end else if (weld_reg < weld_goal) begin
            weld_calc = weld_reg + div_q[WELD_W-1:0];
        end else begin
            weld_calc = weld_reg - div_q[WELD_W-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SPAN;
            ST_SPAN:      state_next = ST_RDIV_GO;
            ST_RDIV_GO:   state_next = ST_RDIV_WAIT;
            ST_RDIV_WAIT: if (div_done) state_next = ST_RATE;
            ST_RATE:      state_next = ST_PHASE;
            ST_PHASE:     state_next = ST_HISS;
            ST_HISS:      state_next = ST_WDIV_GO;
            ST_WDIV_GO: begin
                state_next = (cfg.ramp_time == '0) ? ST_WELD : ST_WDIV_WAIT;
            end
            ST_WDIV_WAIT: if (div_done) state_next = ST_WELD;
            ST_WELD:      state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // operand steering for the shared units
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_go       = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            ST_SPAN: begin
                mul_a = {{(MUL_A_W-RATE_W){1'b0}}, rate_span};
                mul_b = {{(MUL_B_W-SPEED_W){1'b0}}, speed_reg};
            end
            ST_RDIV_GO: begin
                div_go       = 1'b1;
                div_dividend = {{(DIV_N_W-2*RATE_W){1'b0}}, mul_p[2*RATE_W-1:0]};
                div_divisor  = {{(DIV_D_W-SPEED_W){1'b0}}, cap};
            end
            ST_PHASE: begin
                mul_a = {{(MUL_A_W-RATE_W){1'b0}}, rate_reg};
                mul_b = {{(MUL_B_W-ELAPSED_W){1'b0}}, elapsed_reg};
            end
            ST_HISS: begin
                mul_a = {{(MUL_A_W-COEFF_W){1'b0}}, coeff};
                mul_b = {{(MUL_B_W-GAIN_W-1){hiss_diff[GAIN_W]}}, hiss_diff};
            end
            ST_WDIV_GO: begin
                div_go       = (cfg.ramp_time != '0);
                div_dividend = {elapsed_reg, 16'h0000};
                div_divisor  = cfg.ramp_time;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            frac_reg    <= '0;
            hiss_reg    <= '0;
            weld_reg    <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_HISS) begin
                frac_reg <= phase_acc[FRAC_W-1:0];
            end
            if (state_reg == ST_WDIV_GO) begin
                primed_reg <= 1'b1;
                hiss_reg   <= primed_reg ? hiss_sum[GAIN_W-1:0] : hiss_target;
            end
            if (state_reg == ST_WELD) begin
                weld_reg <= weld_calc;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            speed_reg   <= s_speed;
            elapsed_reg <= el_clamp;
            armed_reg   <= s_armed;
        end
        if (state_reg == ST_RATE) begin
            rate_reg <= rate_calc;
        end
        if (state_reg == ST_HISS) begin
            trig_reg <= phase_acc[FRAC_W+TRIG_W-1:FRAC_W];
        end
        if (state_reg == ST_DONE && out_free) begin
            m_trig_reg <= trig_reg;
            m_rate_reg <= rate_reg;
            m_hiss_reg <= hiss_reg;
            m_weld_reg <= weld_reg;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_trigger_count = m_trig_reg;
    assign m_rate_now      = m_rate_reg;
    assign m_hiss_level    = m_hiss_reg;
    assign m_weld_level    = m_weld_reg;

endmodule

// ===== tb/speed_driven_trigger_and_gain_ramps_unit_test.sv =====
// Self-checking bench for speed_driven_trigger_and_gain_ramps_unit (uses hdl/sdtg_pkg.sv).
// A directed table is followed by randomized frames. Each result word is checked against
// a predictor of rate, phase, hiss and weld, or for typed rows against want_* fields.
module speed_driven_trigger_and_gain_ramps_unit_test;
    import sdtg_pkg::*;

    typedef struct packed {
        logic [TRIG_W-1:0] trig;
        logic [RATE_W-1:0] rate;
        logic [GAIN_W-1:0] hiss;
        logic [WELD_W-1:0] weld;
    } frame_result_t;

    // one directed frame; want_* only meaningful when typed is set
    typedef struct packed {
        logic [2:0]           grp;
        logic [SPEED_W-1:0]   speed;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 armed;
        logic                 typed;
        logic [TRIG_W-1:0]    want_trig;
        logic [RATE_W-1:0]    want_rate;
        logic [GAIN_W-1:0]    want_hiss;
        logic [WELD_W-1:0]    want_weld;
    } frame_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [SPEED_W-1:0]    s_speed = '0;
    logic [ELAPSED_W-1:0]  s_elapsed = '0;
    logic                  s_armed = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TRIG_W-1:0]     m_trigger_count;
    logic [RATE_W-1:0]     m_rate_now;
    logic [GAIN_W-1:0]     m_hiss_level;
    logic [WELD_W-1:0]     m_weld_level;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of registers and state, reset values
    cfg_t               regs = {16'd0, 16'd0, 16'd64, 16'd0, 16'd0, 16'd0, 17'd65536, 24'd0};
    logic [FRAC_W-1:0]  phase_acc = '0;
    logic [GAIN_W-1:0]  hiss_now = '0;
    logic [WELD_W-1:0]  weld_now = '0;
    logic               hiss_primed = 1'b0;

    frame_result_t due_results[$];
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            hold_left = 0;

    // directed register sets, group 0 runs on reset defaults
    cfg_t dir_cfg [1:4] = '{
        {16'd65535, 16'd0,     16'd0,     16'd65535, 16'd0,     16'd32,    17'd131071, 24'd0},
        {16'd0,     16'd65535, 16'd65535, 16'd0,     16'd65535, 16'd65535, 17'd0,  24'd16777215},
        {16'd1000,  16'd3000,  16'd6400,  16'd4096,  16'd16384, 16'd640,   17'd8192,   24'd1},
        {16'd200,   16'd100,   16'd1,     16'd65535, 16'd1,     16'd1,     17'd65536,  24'd1048576}
    };

    frame_row_t dir_rows [21] = '{
        // reset defaults: zero rates and gains, snapping weld
        {3'd0, 16'd0,     21'd0,       1'b0, 1'b1, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd0, 16'd65535, 21'd2097151, 1'b1, 1'b1, 13'd0,    16'd0,     16'd0,     17'd65536},
        {3'd0, 16'd100,   21'd1048576, 1'b0, 1'b1, 13'd0,    16'd0,     16'd0,     17'd0},
        // zero cap, falling rate, coefficient over one; second row crosses 4096
        {3'd1, 16'd0,     21'd1048576, 1'b1, 1'b1, 13'd4095, 16'd65535, 16'd65535, 17'd65536},
        {3'd1, 16'd0,     21'd1048576, 1'b0, 1'b1, 13'd4096, 16'd65535, 16'd65535, 17'd0},
        {3'd1, 16'd32,    21'd2097151, 1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd1, 16'd63,    21'd1,       1'b0, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd1, 16'd64,    21'd12345,   1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        // full-scale cap and ramp, frozen hiss
        {3'd2, 16'd65535, 21'd1048576, 1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd2, 16'd65534, 21'd2097151, 1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd2, 16'd1,     21'd0,       1'b0, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd2, 16'd0,     21'd1048576, 1'b0, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        // mid-range interpolation, partial smoothing both ways, one-tick ramp
        {3'd3, 16'd3200,  21'd17476,   1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd3, 16'd100,   21'd17476,   1'b0, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd3, 16'd640,   21'd1,       1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd3, 16'd639,   21'd33333,   1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd3, 16'd65535, 21'd699050,  1'b0, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        // ramp_time of 1048576, partial weld steps up and a full step down
        {3'd4, 16'd0,     21'd16,      1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd4, 16'd5,     21'd524288,  1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd4, 16'd0,     21'd1048576, 1'b0, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0},
        {3'd4, 16'd1,     21'd1048575, 1'b1, 1'b0, 13'd0,    16'd0,     16'd0,     17'd0}
    };

    speed_driven_trigger_and_gain_ramps_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_speed         (s_speed),
        .s_elapsed       (s_elapsed),
        .s_armed         (s_armed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_count (m_trigger_count),
        .m_rate_now      (m_rate_now),
        .m_hiss_level    (m_hiss_level),
        .m_weld_level    (m_weld_level),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 aclk = ~aclk;

    // one frame through rate map, phase accumulator, hiss filter and weld slew
    function automatic frame_result_t advance_frame(input logic [SPEED_W-1:0] spd,
                                                    input logic [ELAPSED_W-1:0] el_in,
                                                    input logic arm);
        longint unsigned el, cap, lo, hi, rate, acc, step, w, w_goal;
        longint          tgt, coeff, nxt;
        frame_result_t   r;
        el = (el_in > ELAPSED_MAX) ? ELAPSED_MAX : el_in;
        cap = (regs.speed_cap == '0) ? DEFAULT_CAP : regs.speed_cap;
        lo = regs.rate_low;
        hi = regs.rate_high;
        if (spd >= cap)
            rate = hi;
        else if (hi >= lo)
            rate = lo + (hi - lo) * spd / cap;
        else
            rate = lo - ((lo - hi) * spd + cap - 1) / cap;   // falling span rounds rate down
        acc = phase_acc + rate * el;
        r.trig = TRIG_W'(acc >> FRAC_W);
        r.rate = RATE_W'(rate);
        phase_acc = FRAC_W'(acc);

        tgt = (spd >= regs.active_speed) ? regs.active_gain : regs.idle_gain;
        if (!hiss_primed) begin
            hiss_now = GAIN_W'(tgt);
            hiss_primed = 1'b1;
        end else begin
            coeff = (regs.smooth_coeff > ONE_Q16) ? ONE_Q16 : regs.smooth_coeff;
            // arithmetic shift floors negative steps
            nxt = longint'(hiss_now) + ((coeff * (tgt - longint'(hiss_now))) >>> 16);
            hiss_now = GAIN_W'(nxt);
        end

        w = weld_now;
        w_goal = arm ? ONE_Q16 : 0;
        if (regs.ramp_time == '0) begin
            w = w_goal;
        end else begin
            step = (el << 16) / regs.ramp_time;
            if (w < w_goal)
                w = (w + step > w_goal) ? w_goal : w + step;
            else
                w = (step >= w - w_goal) ? w_goal : w - step;
        end
        weld_now = WELD_W'(w);
        r.hiss = hiss_now;
        r.weld = weld_now;
        return r;
    endfunction

    function automatic logic [15:0] pick_edge16();
        case ($urandom_range(3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            REG_RATE_LOW:     regs.rate_low = d[15:0];
            REG_RATE_HIGH:    regs.rate_high = d[15:0];
            REG_SPEED_CAP:    regs.speed_cap = d[15:0];
            REG_IDLE_GAIN:    regs.idle_gain = d[15:0];
            REG_ACTIVE_GAIN:  regs.active_gain = d[15:0];
            REG_ACTIVE_SPEED: regs.active_speed = d[15:0];
            REG_SMOOTH_COEFF: regs.smooth_coeff = d[16:0];
            REG_RAMP_TIME:    regs.ramp_time = d;
            default: ;
        endcase
    endtask

    // unused upper data bits carry noise, the unit must drop them
    task automatic load_settings(input cfg_t c);
        write_reg(REG_RATE_LOW,     {8'($urandom), c.rate_low});
        write_reg(REG_RATE_HIGH,    {8'($urandom), c.rate_high});
        write_reg(REG_SPEED_CAP,    {8'($urandom), c.speed_cap});
        write_reg(REG_IDLE_GAIN,    {8'($urandom), c.idle_gain});
        write_reg(REG_ACTIVE_GAIN,  {8'($urandom), c.active_gain});
        write_reg(REG_ACTIVE_SPEED, {8'($urandom), c.active_speed});
        write_reg(REG_SMOOTH_COEFF, {7'($urandom), c.smooth_coeff});
        write_reg(REG_RAMP_TIME,    c.ramp_time);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // returns in the time step of acceptance with s_valid still high
    task automatic send_frame(input logic [SPEED_W-1:0] spd, input logic [ELAPSED_W-1:0] el,
                              input logic arm, input logic typed,
                              input frame_result_t typed_want);
        frame_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_speed <= spd;
        s_elapsed <= el;
        s_armed <= arm;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_frame(spd, el, arm);
        due_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain_results();
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: trig %0d rate %0d hiss %0d weld %0d",
                             m_trigger_count, m_rate_now, m_hiss_level, m_weld_level);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (m_trigger_count !== want.trig || m_rate_now !== want.rate ||
                    m_hiss_level !== want.hiss || m_weld_level !== want.weld) begin
                    if (mismatches < 10)
                        $display("mismatch exp/got: trig %0d/%0d rate %0d/%0d hiss %0d/%0d weld %0d/%0d",
                                 want.trig, m_trigger_count, want.rate, m_rate_now,
                                 want.hiss, m_hiss_level, want.weld, m_weld_level);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : run
        cfg_t             next_cfg;
        logic [2:0]       grp;
        logic [SPEED_W-1:0]   spd;
        logic [ELAPSED_W-1:0] el;
        logic             arm_now;
        int               cap_eff;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        grp = 3'd0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].grp != grp) begin
                s_valid <= 1'b0;
                drain_results();
                grp = dir_rows[i].grp;
                load_settings(dir_cfg[grp]);
            end
            send_frame(dir_rows[i].speed, dir_rows[i].elapsed, dir_rows[i].armed,
                       dir_rows[i].typed, {dir_rows[i].want_trig, dir_rows[i].want_rate,
                                           dir_rows[i].want_hiss, dir_rows[i].want_weld});
        end

        arm_now = 1'b0;
        for (int ph = 0; ph < 5; ph++) begin
            for (int blk = 0; blk < 3; blk++) begin
                s_valid <= 1'b0;
                drain_results();
                case (ph)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 45; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 45; end
                    3: begin send_idle_pct = 31; stall_pct = 31; end
                    default: begin send_idle_pct = 0; stall_pct = 20; end
                endcase

                next_cfg.rate_low = pick_edge16();
                next_cfg.rate_high = pick_edge16();
                case ($urandom_range(5))
                    0: next_cfg.speed_cap = 16'd0;
                    1: next_cfg.speed_cap = 16'd64;
                    2: next_cfg.speed_cap = 16'hFFFF;
                    3: next_cfg.speed_cap = 16'($urandom_range(1, 2000));
                    default: next_cfg.speed_cap = 16'($urandom);
                endcase
                next_cfg.idle_gain = pick_edge16();
                next_cfg.active_gain = pick_edge16();
                next_cfg.active_speed = ($urandom_range(1) == 0) ? pick_edge16()
                                                                 : 16'($urandom_range(0, 4000));
                case ($urandom_range(4))
                    0: next_cfg.smooth_coeff = 17'd0;
                    1: next_cfg.smooth_coeff = ONE_Q16;
                    2: next_cfg.smooth_coeff = 17'($urandom_range(65537, 131071));
                    3: next_cfg.smooth_coeff = 17'($urandom_range(256, 16384));
                    default: next_cfg.smooth_coeff = 17'($urandom_range(1, 65535));
                endcase
                case ($urandom_range(4))
                    0: next_cfg.ramp_time = 24'd0;
                    1: next_cfg.ramp_time = 24'hFFFFFF;
                    2: next_cfg.ramp_time = 24'($urandom_range(1, 4096));
                    3: next_cfg.ramp_time = 24'($urandom_range(4096, 2000000));
                    default: next_cfg.ramp_time = 24'($urandom);
                endcase
                load_settings(next_cfg);

                for (int n = 0; n < 50; n++) begin
                    // long receiver hold-off so the unit backs up and drops s_ready
                    if (ph == 4 && blk < 2 && n == 5)
                        hold_left <= 500;
                    cap_eff = (regs.speed_cap == '0) ? DEFAULT_CAP : regs.speed_cap;
                    case ($urandom_range(7))
                        0: spd = 16'd0;
                        1: spd = 16'hFFFF;
                        2: spd = 16'($urandom_range(0, cap_eff));
                        3: spd = 16'(regs.active_speed + $urandom_range(0, 2) - 1);
                        default: spd = 16'($urandom);
                    endcase
                    case ($urandom_range(9))
                        0: el = 21'd0;
                        1: el = ELAPSED_MAX;
                        2: el = 21'($urandom_range(1048577, 2097151));
                        3: el = 21'h1FFFFF;
                        4, 5: el = 21'($urandom_range(10000, 50000));
                        default: el = 21'($urandom);
                    endcase
                    // armed runs in stretches so the weld level can reach both ends
                    if ($urandom_range(5) == 0)
                        arm_now = ~arm_now;
                    send_frame(spd, el, arm_now, 1'b0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
